[design/assert_macros.svh]
// Assertion macros shared by the log-volatility filter RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Property checked on every rising clock edge outside reset.
`define LVKF_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("lvkf assertion failed");
// Expression that must never hold outside reset.
`define LVKF_NEVER(label, clk, rst, expr) \
   label: assert property (@(posedge clk) disable iff (rst) !(expr)) \
      else $error("lvkf forbidden condition");
`else
`define LVKF_ASSERT(label, clk, rst, prop)
`define LVKF_NEVER(label, clk, rst, expr)
`endif
`endif

[design/lvkf_pkg.sv]
// Types and constants of the log-volatility Kalman filter.
`timescale 1ns / 1ps
`default_nettype none
package lvkf_pkg;

   localparam int FRAC_BITS  = 16;
   localparam int DIV_NUM_W  = 80;
   localparam int DIV_DEN_W  = 34;
   localparam int DIV_STEPS  = 33;
   localparam int LOG_STEPS  = 24;
   localparam logic [29:0] LN2_Q30 = 30'd744261118;

   // reset values of the control registers
   localparam logic signed [17:0] AR_COEF_RST  = 18'sd62259;
   localparam logic [30:0]        NOISE_SD_RST = 31'd13107;
   localparam logic signed [31:0] LEVEL_RST    = 32'sd0;
   localparam logic signed [31:0] OBS_MEAN_RST = -32'sd83257;
   localparam logic [30:0]        OBS_VAR_RST  = 31'd323409;

   typedef enum logic [2:0] {
      CSR_AR_COEF  = 3'd0,
      CSR_NOISE_SD = 3'd1,
      CSR_LEVEL    = 3'd2,
      CSR_OBS_MEAN = 3'd3,
      CSR_OBS_VAR  = 3'd4
   } csr_index_type;

   typedef struct packed {
      logic signed [31:0] obs;
      logic               block_start;
      logic               series_start;
      logic signed [31:0] prior_state;
      logic               block_end;
   } req_type;

   typedef struct packed {
      logic signed [31:0] filt_mean;
      logic [30:0]        filt_var;
      logic               block_last;
      logic               saturated;
   } rsp_type;

   typedef struct packed {
      logic                 start;
      logic [DIV_NUM_W-1:0] num;
      logic [DIV_DEN_W-1:0] den;
   } div_req_type;

   typedef struct packed {
      logic                 done;
      logic                 ovf;
      logic [DIV_STEPS-1:0] quot;
   } div_rsp_type;

   typedef enum logic [1:0] {
      DIV_STAT = 2'd0,
      DIV_MEAN = 2'd1,
      DIV_VAR  = 2'd2
   } div_kind_type;

   typedef enum logic [25:0] {
      S_IDLE = 26'd1,
      S_SIG  = 26'd2,
      S_SIGR = 26'd4,
      S_PHI2 = 26'd8,
      S_DD   = 26'd16,
      S_PRI  = 26'd32,
      S_PRIR = 26'd64,
      S_LOGN = 26'd128,
      S_NORM = 26'd256,
      S_SQ   = 26'd512,
      S_SQR  = 26'd1024,
      S_LN   = 26'd2048,
      S_LNR  = 26'd4096,
      S_DIFF = 26'd8192,
      S_NUM1 = 26'd16384,
      S_NUM2 = 26'd32768,
      S_NUM3 = 26'd65536,
      S_DIVW = 26'd131072,
      S_VMUL = 26'd262144,
      S_VDIV = 26'd524288,
      S_PRED = 26'd1048576,
      S_PM   = 26'd2097152,
      S_T    = 26'd4194304,
      S_T2   = 26'd8388608,
      S_PV   = 26'd16777216,
      S_OUT  = 26'd33554432
   } state_type;

endpackage
`default_nettype wire

[design/lvkf_div.sv]
// Restoring divider, one quotient bit per cycle, with overflow precheck.
`timescale 1ns / 1ps
`default_nettype none
module lvkf_div (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire lvkf_pkg::div_req_type div_req,
   output lvkf_pkg::div_rsp_type      div_rsp
);
   import lvkf_pkg::*;

   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic                 ovf_ff, ovf_in;
   logic [5:0]           cnt_ff, cnt_in;
   logic [DIV_DEN_W-1:0] rem_ff, rem_in;
   logic [DIV_DEN_W-1:0] den_ff, den_in;
   logic [DIV_STEPS-1:0] low_ff, low_in;
   logic [DIV_STEPS-1:0] quot_ff, quot_in;
   logic [DIV_DEN_W:0]   trial;

   // next state of the shift-subtract loop
   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      ovf_in  = ovf_ff;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      low_in  = low_ff;
      quot_in = quot_ff;
      trial   = {rem_ff, low_ff[DIV_STEPS-1]};
      if (div_req.start) begin
         den_in  = div_req.den;
         quot_in = '0;
         low_in  = div_req.num[DIV_STEPS-1:0];
         rem_in  = div_req.num[DIV_STEPS+DIV_DEN_W-1:DIV_STEPS];
         // quotient would not fit in the step count
         if (div_req.num[DIV_NUM_W-1:DIV_STEPS] >=
             {{(DIV_NUM_W-DIV_STEPS-DIV_DEN_W){1'b0}}, div_req.den}) begin
            ovf_in  = 1'b1;
            done_in = 1'b1;
         end else begin
            ovf_in  = 1'b0;
            busy_in = 1'b1;
            cnt_in  = 6'(DIV_STEPS);
         end
      end else if (busy_ff) begin
         if (trial >= {1'b0, den_ff}) begin
            rem_in  = DIV_DEN_W'(trial - {1'b0, den_ff});
            quot_in = {quot_ff[DIV_STEPS-2:0], 1'b1};
         end else begin
            rem_in  = trial[DIV_DEN_W-1:0];
            quot_in = {quot_ff[DIV_STEPS-2:0], 1'b0};
         end
         low_in = {low_ff[DIV_STEPS-2:0], 1'b0};
         cnt_in = cnt_ff - 6'd1;
         if (cnt_ff == 6'd1) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      ovf_ff  <= ovf_in;
      cnt_ff  <= cnt_in;
      rem_ff  <= rem_in;
      den_ff  <= den_in;
      low_ff  <= low_in;
      quot_ff <= quot_in;
   end

   assign div_rsp.done = done_ff;
   assign div_rsp.ovf  = ovf_ff;
   assign div_rsp.quot = quot_ff;

endmodule
`default_nettype wire

[design/log_volatility_kalman_filter.sv]
// Top level: scalar Kalman filter for AR(1) log volatility, shared-multiplier sequencer.
//
//   channel | direction | handshake          | payload
//   req     | in        | req_valid/req_stall | lvkf_pkg::req_type
//   rsp     | out       | rsp_valid/rsp_stall | lvkf_pkg::rsp_type
//   csr     | in        | csr_valid/csr_ready | csr_index, csr_wdata
//
// Per item the sequencer runs up to 31 normalize shifts and 24 squarings, the squarings
// through the one 34x34 multiplier, and up to three 33-step divisions in the shared divider.
// A new item is taken once the sequencer is back in idle,
// even while the last result still waits on rsp_stall.
// Reset is synchronous and loads the register defaults and a zero prediction.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module log_volatility_kalman_filter (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_stall,
   input  wire lvkf_pkg::req_type req_data,
   output logic                   rsp_valid,
   input  wire logic              rsp_stall,
   output lvkf_pkg::rsp_type      rsp_data,
   input  wire logic              csr_valid,
   output logic                   csr_ready,
   input  wire logic [2:0]        csr_index,
   input  wire logic [31:0]       csr_wdata
);
   import lvkf_pkg::*;

   localparam logic signed [67:0] SMAX68 = 68'sd2147483647;
   localparam logic signed [67:0] SMIN68 = -68'sd2147483648;
   localparam logic [32:0]        CAP_POS = 33'd2147483647;
   localparam logic [32:0]        CAP_NEG = 33'd2147483648;

   // rounded right shift, ties away from zero
   function automatic logic signed [67:0] rnd_shr(input logic signed [67:0] x,
                                                  input int unsigned s);
      logic [67:0] mg;
      logic [67:0] r;
      mg = x[67] ? 68'(-x) : x;
      r  = (mg + (68'd1 << (s - 1))) >> s;
      return x[67] ? 68'(-r) : r;
   endfunction

   function automatic logic signed [31:0] sat_s(input logic signed [67:0] x);
      if (x > SMAX68) return 32'sh7FFFFFFF;
      if (x < SMIN68) return 32'sh80000000;
      return x[31:0];
   endfunction

   function automatic logic [30:0] sat_v(input logic signed [67:0] x);
      if (x > SMAX68) return 31'h7FFFFFFF;
      if (x[67])      return 31'd0;
      return x[30:0];
   endfunction

   state_type            state_ff, state_in;
   logic signed [17:0]   phi_ff, phi_in;
   logic [30:0]          sd_ff, sd_in;
   logic signed [31:0]   mu_ff, mu_in;
   logic signed [31:0]   onm_ff, onm_in;
   logic [30:0]          onv_ff, onv_in;
   logic signed [31:0]   pm_ff, pm_in;
   logic [30:0]          pv_ff, pv_in;
   req_type              item_ff, item_in;
   logic                 sat_ff, sat_in;
   logic signed [67:0]   prod_ff, prod_in;
   logic signed [67:0]   acc_ff, acc_in;
   logic [61:0]          sig2q_ff, sig2q_in;
   logic [46:0]          sig2_ff, sig2_in;
   logic [31:0]          x_ff, x_in;
   logic [4:0]           e_ff, e_in;
   logic [23:0]          frac_ff, frac_in;
   logic [4:0]           cnt_ff, cnt_in;
   logic signed [31:0]   yp_ff, yp_in;
   logic signed [31:0]   d_ff, d_in;
   logic [31:0]          den_ff, den_in;
   logic                 neg_ff, neg_in;
   logic signed [31:0]   fm_ff, fm_in;
   logic [30:0]          fv_ff, fv_in;
   logic signed [33:0]   t_ff, t_in;
   div_kind_type         kind_ff, kind_in;
   rsp_type              rsp_ff, rsp_in;
   logic                 rsp_valid_ff, rsp_valid_in;

   logic signed [33:0]   mul_a, mul_b;
   div_req_type          div_req;
   div_rsp_type          div_rsp;

   logic signed [67:0]   shr_t;
   logic signed [67:0]   wide_t;
   logic signed [32:0]   diff33;
   logic signed [29:0]   l2;
   logic [32:0]          sq33;
   logic [33:0]          rsum;
   logic [32:0]          rq;
   logic [32:0]          mq;
   logic [63:0]          mag64;
   logic                 out_free;

   lvkf_div u_div (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   assign req_stall = (state_ff != S_IDLE);
   assign csr_ready = 1'b1;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;
   assign out_free  = !rsp_valid_ff || !rsp_stall;

   // shared multiplier operand select
   always_comb begin
      mul_a  = '0;
      mul_b  = '0;
      diff33 = '0;
      l2     = 30'(signed'({~e_ff[4], e_ff[3:0], frac_ff, 1'b0}));
      case (state_ff)
         S_SIG: begin
            mul_a = {3'b0, sd_ff};
            mul_b = {3'b0, sd_ff};
         end
         S_PHI2: begin
            mul_a = {{16{phi_ff[17]}}, phi_ff};
            mul_b = {{16{phi_ff[17]}}, phi_ff};
         end
         S_PRI: begin
            diff33 = {item_ff.prior_state[31], item_ff.prior_state} - {mu_ff[31], mu_ff};
            mul_a  = {{16{phi_ff[17]}}, phi_ff};
            mul_b  = {diff33[32], diff33};
         end
         S_SQ: begin
            mul_a = {2'b0, x_ff};
            mul_b = {2'b0, x_ff};
         end
         S_LN: begin
            mul_a = {{4{l2[29]}}, l2};
            mul_b = {4'b0, LN2_Q30};
         end
         S_NUM1: begin
            mul_a = {3'b0, onv_ff};
            mul_b = {{2{pm_ff[31]}}, pm_ff};
         end
         S_NUM2: begin
            mul_a = {3'b0, pv_ff};
            mul_b = {{2{d_ff[31]}}, d_ff};
         end
         S_VMUL: begin
            mul_a = {3'b0, pv_ff};
            mul_b = {3'b0, onv_ff};
         end
         S_PRED: begin
            diff33 = {fm_ff[31], fm_ff} - {mu_ff[31], mu_ff};
            mul_a  = {{16{phi_ff[17]}}, phi_ff};
            mul_b  = {diff33[32], diff33};
         end
         S_PM: begin
            mul_a = {{16{phi_ff[17]}}, phi_ff};
            mul_b = {3'b0, fv_ff};
         end
         S_T2: begin
            mul_a = {{16{phi_ff[17]}}, phi_ff};
            mul_b = t_ff;
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
      prod_in = mul_a * mul_b;
   end

   // sequencer
   always_comb begin
      state_in     = state_ff;
      phi_in       = phi_ff;
      sd_in        = sd_ff;
      mu_in        = mu_ff;
      onm_in       = onm_ff;
      onv_in       = onv_ff;
      pm_in        = pm_ff;
      pv_in        = pv_ff;
      item_in      = item_ff;
      sat_in       = sat_ff;
      acc_in       = acc_ff;
      sig2q_in     = sig2q_ff;
      sig2_in      = sig2_ff;
      x_in         = x_ff;
      e_in         = e_ff;
      frac_in      = frac_ff;
      cnt_in       = cnt_ff;
      yp_in        = yp_ff;
      d_in         = d_ff;
      den_in       = den_ff;
      neg_in       = neg_ff;
      fm_in        = fm_ff;
      fv_in        = fv_ff;
      t_in         = t_ff;
      kind_in      = kind_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      div_req      = '0;
      shr_t        = '0;
      wide_t       = '0;
      sq33         = prod_ff[63:31];
      rsum         = {1'b0, div_rsp.quot} + 34'd1;
      rq           = rsum[33:1];
      mq           = '0;
      mag64        = '0;

      // register writes; the host writes only while no item is in flight (a rule for the host, not enforced here)
      if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_AR_COEF:  phi_in = csr_wdata[17:0];
            CSR_NOISE_SD: sd_in  = csr_wdata[30:0];
            CSR_LEVEL:    mu_in  = csr_wdata;
            CSR_OBS_MEAN: onm_in = csr_wdata;
            CSR_OBS_VAR:  onv_in = csr_wdata[30:0];
            default: ;
         endcase
      end

      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               item_in  = req_data;
               sat_in   = 1'b0;
               state_in = S_SIG;
            end
         end
         S_SIG: state_in = S_SIGR;
         S_SIGR: begin
            sig2q_in = prod_ff[61:0];
            shr_t    = rnd_shr(prod_ff, FRAC_BITS);
            sig2_in  = shr_t[46:0];
            if (item_ff.block_start && item_ff.series_start) state_in = S_PHI2;
            else if (item_ff.block_start)                   state_in = S_PRI;
            else                                            state_in = S_LOGN;
         end
         S_PHI2: state_in = S_DD;
         S_DD: begin
            // stationary variance sigma^2 / (1 - phi^2)
            wide_t = (68'sd1 <<< 32) - prod_ff;
            pm_in  = mu_ff;
            if (wide_t <= 68'sd0) begin
               pv_in    = 31'h7FFFFFFF;
               sat_in   = 1'b1;
               state_in = S_LOGN;
            end else begin
               div_req.start = 1'b1;
               div_req.num   = {1'b0, sig2q_ff, 17'b0};
               div_req.den   = wide_t[33:0];
               kind_in       = DIV_STAT;
               state_in      = S_DIVW;
            end
         end
         S_PRI: state_in = S_PRIR;
         S_PRIR: begin
            pm_in    = sat_s({{36{mu_ff[31]}}, mu_ff} + rnd_shr(prod_ff, FRAC_BITS));
            pv_in    = sat_v({21'b0, sig2_ff});
            state_in = S_LOGN;
         end
         S_LOGN: begin
            if (item_ff.obs == 32'sd0) begin
               yp_in    = 32'sh80000000;
               sat_in   = 1'b1;
               state_in = S_DIFF;
            end else begin
               x_in     = item_ff.obs[31] ? 32'(-item_ff.obs) : item_ff.obs;
               e_in     = 5'd31;
               state_in = S_NORM;
            end
         end
         S_NORM: begin
            // one leading-zero shift per cycle
            if (x_ff[31]) begin
               cnt_in   = '0;
               frac_in  = '0;
               state_in = S_SQ;
            end else begin
               x_in = {x_ff[30:0], 1'b0};
               e_in = e_ff - 5'd1;
            end
         end
         S_SQ: state_in = S_SQR;
         S_SQR: begin
            // one fraction bit of log2 per squaring
            if (sq33[32]) begin
               x_in    = sq33[32:1];
               frac_in = {frac_ff[22:0], 1'b1};
            end else begin
               x_in    = sq33[31:0];
               frac_in = {frac_ff[22:0], 1'b0};
            end
            cnt_in   = cnt_ff + 5'd1;
            state_in = (cnt_ff == 5'(LOG_STEPS - 1)) ? S_LN : S_SQ;
         end
         S_LN: state_in = S_LNR;
         S_LNR: begin
            yp_in    = sat_s(rnd_shr(prod_ff, 38));
            state_in = S_DIFF;
         end
         S_DIFF: begin
            d_in     = sat_s({{36{yp_ff[31]}}, yp_ff} - {{36{onm_ff[31]}}, onm_ff});
            den_in   = {1'b0, pv_ff} + {1'b0, onv_ff};
            state_in = S_NUM1;
         end
         S_NUM1: state_in = S_NUM2;
         S_NUM2: begin
            acc_in   = prod_ff;
            state_in = S_NUM3;
         end
         S_NUM3: begin
            wide_t = acc_ff + prod_ff;
            mag64  = wide_t[67] ? 64'(-wide_t) : wide_t[63:0];
            neg_in = wide_t[67];
            if (den_ff == 32'd0) begin
               fm_in    = pm_ff;
               fv_in    = '0;
               state_in = S_PRED;
            end else begin
               div_req.start = 1'b1;
               div_req.num   = {15'b0, mag64, 1'b0};
               div_req.den   = {2'b0, den_ff};
               kind_in       = DIV_MEAN;
               state_in      = S_DIVW;
            end
         end
         S_DIVW: begin
            if (div_rsp.done) begin
               case (kind_ff)
                  DIV_STAT: begin
                     mq       = (div_rsp.ovf || rq > CAP_POS) ? CAP_POS : rq;
                     pv_in    = mq[30:0];
                     state_in = S_LOGN;
                  end
                  DIV_MEAN: begin
                     if (neg_ff) begin
                        mq    = (div_rsp.ovf || rq > CAP_NEG) ? CAP_NEG : rq;
                        fm_in = 32'(-mq);
                     end else begin
                        mq    = (div_rsp.ovf || rq > CAP_POS) ? CAP_POS : rq;
                        fm_in = mq[31:0];
                     end
                     state_in = S_VMUL;
                  end
                  DIV_VAR: begin
                     mq       = (div_rsp.ovf || rq > CAP_POS) ? CAP_POS : rq;
                     fv_in    = mq[30:0];
                     state_in = S_PRED;
                  end
                  default: state_in = S_IDLE;
               endcase
            end
         end
         S_VMUL: state_in = S_VDIV;
         S_VDIV: begin
            div_req.start = 1'b1;
            div_req.num   = {16'b0, prod_ff[62:0], 1'b0};
            div_req.den   = {2'b0, den_ff};
            kind_in       = DIV_VAR;
            state_in      = S_DIVW;
         end
         S_PRED: state_in = S_PM;
         S_PM: begin
            pm_in    = sat_s({{36{mu_ff[31]}}, mu_ff} + rnd_shr(prod_ff, FRAC_BITS));
            state_in = S_T;
         end
         S_T: begin
            shr_t    = rnd_shr(prod_ff, FRAC_BITS);
            t_in     = shr_t[33:0];
            state_in = S_T2;
         end
         S_T2: state_in = S_PV;
         S_PV: begin
            pv_in    = sat_v(rnd_shr(prod_ff, FRAC_BITS) + {21'b0, sig2_ff});
            state_in = S_OUT;
         end
         S_OUT: begin
            if (out_free) begin
               rsp_in.filt_mean  = fm_ff;
               rsp_in.filt_var   = fv_ff;
               rsp_in.block_last = item_ff.block_end;
               rsp_in.saturated  = sat_ff;
               rsp_valid_in      = 1'b1;
               state_in          = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         phi_ff       <= AR_COEF_RST;
         sd_ff        <= NOISE_SD_RST;
         mu_ff        <= LEVEL_RST;
         onm_ff       <= OBS_MEAN_RST;
         onv_ff       <= OBS_VAR_RST;
         pm_ff        <= '0;
         pv_ff        <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         phi_ff       <= phi_in;
         sd_ff        <= sd_in;
         mu_ff        <= mu_in;
         onm_ff       <= onm_in;
         onv_ff       <= onv_in;
         pm_ff        <= pm_in;
         pv_ff        <= pv_in;
      end
      item_ff  <= item_in;
      sat_ff   <= sat_in;
      prod_ff  <= prod_in;
      acc_ff   <= acc_in;
      sig2q_ff <= sig2q_in;
      sig2_ff  <= sig2_in;
      x_ff     <= x_in;
      e_ff     <= e_in;
      frac_ff  <= frac_in;
      cnt_ff   <= cnt_in;
      yp_ff    <= yp_in;
      d_ff     <= d_in;
      den_ff   <= den_in;
      neg_ff   <= neg_in;
      fm_ff    <= fm_in;
      fv_ff    <= fv_in;
      t_ff     <= t_in;
      kind_ff  <= kind_in;
      rsp_ff   <= rsp_in;
   end

   // checks
   `LVKF_ASSERT(a_div_done_in_wait, clock, reset, div_rsp.done |-> state_ff == S_DIVW)
   `LVKF_ASSERT(a_rsp_from_out, clock, reset, $rose(rsp_valid_ff) |-> $past(state_ff) == S_OUT)
   `LVKF_ASSERT(a_out_holds, clock, reset, (state_ff == S_OUT && !out_free) |=> state_ff == S_OUT)

endmodule
`default_nettype wire
